// ===== rtl/psdht_pkg.sv =====
package psdht_pkg;

  localparam int CoordW     = 16;
  localparam int DiffW      = CoordW + 1;
  localparam int ProdW      = 2 * DiffW;
  localparam int DotW       = ProdW + 1;
  localparam int HalfW      = ProdW / 2;
  localparam int R2W        = 2 * CoordW;
  localparam int SqW        = 2 * ProdW;
  localparam int RdW        = R2W + ProdW;
  localparam int FracBits   = 4;
  localparam int DistW      = 21;
  localparam int QuotW      = 2 * DistW;
  localparam int DivSteps   = QuotW;
  localparam int SqrtSteps  = DistW;
  localparam int SremW      = DistW + 2;

  localparam logic [CoordW-1:0] RadiusRst = 16'd10;
  localparam logic [R2W-1:0]    Radius2Rst = R2W'(RadiusRst) * R2W'(RadiusRst);

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
  } in_t;

  typedef struct packed {
    logic [DistW-1:0] seg_distance;
    logic             hit;
  } out_t;

endpackage

// ===== rtl/point_segment_distance_hit_test.sv =====
// Throughput: one item per cycle; busy is low whenever reset is released.
// Most of the depth is a 42-stage quotient pipeline (one bit per stage)
// followed by a 21-stage square root pipeline (one root bit per stage).
// Reset (rst_n low, synchronous) clears all valid bits and sets radius_r to 10.
module point_segment_distance_hit_test (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  psdht_pkg::in_t                in_data,
  output logic                          out_strobe,
  output psdht_pkg::out_t               out_data,
  input  logic                          cfg_we,
  input  logic [psdht_pkg::CoordW-1:0]  cfg_wdata
);
  import psdht_pkg::*;

  logic [CoordW-1:0] radius_r;
  logic [R2W-1:0]    r2_r;

  // stage 0: input register
  logic v0_r;
  in_t  in0_r;

  // stage 1: differences
  logic v1_r;
  logic signed [DiffW-1:0] dx1_r, dy1_r, wx1_r, wy1_r, ux1_r, uy1_r;
  logic signed [DiffW-1:0] dx1_nxt, dy1_nxt, wx1_nxt, wy1_nxt, ux1_nxt, uy1_nxt;

  // stage 2: products
  logic v2_r;
  logic signed [ProdW-1:0] pdx2_r, pdy2_r, ptx2_r, pty2_r, pca2_r, pcb2_r;
  logic signed [ProdW-1:0] pax2_r, pay2_r, pbx2_r, pby2_r;

  // stage 3: sums
  logic v3_r;
  logic [ProdW-1:0]      dd3_r, sqa3_r, sqb3_r;
  logic signed [DotW-1:0] t3_r, cr3_r;

  // stage 4: case select
  logic v4_r;
  logic              perp4_r, perp4_nxt;
  logic [ProdW-1:0]  c4_r, den4_r, sq4_r;
  logic [ProdW-1:0]  c4_nxt, den4_nxt, sq4_nxt;
  logic              t_pos;

  // stage 5: partial products
  logic v5_r;
  logic              perp5_r;
  logic [ProdW-1:0]  sq5_r, den5_r;
  logic [ProdW-1:0]  hh5_r, hl5_r, ll5_r;
  logic [R2W+HalfW-1:0] rh5_r, rl5_r;

  // stage 6: wide sums
  logic v6_r;
  logic [SqW-1:0]   num6_r, num6_nxt, c2_6;
  logic [RdW-1:0]   rd6_r;
  logic [ProdW-1:0] den6_r;

  // divider pipeline, index 0 is the init stage
  logic             dv_r    [DivSteps+1];
  logic [ProdW-1:0] drem_r  [DivSteps+1];
  logic [QuotW-1:0] dnb_r   [DivSteps+1];
  logic [QuotW-1:0] dq_r    [DivSteps+1];
  logic [ProdW-1:0] dden_r  [DivSteps+1];
  logic             dhit_r  [DivSteps+1];
  logic [ProdW-1:0] drem_nxt [DivSteps];
  logic [QuotW-1:0] dq_nxt   [DivSteps];
  logic [ProdW:0]   dtry     [DivSteps];

  // square root pipeline; step 0 takes the last divider stage
  logic             sv_r    [1:SqrtSteps];
  logic [SremW-1:0] srem_r  [1:SqrtSteps];
  logic [DistW-1:0] sroot_r [1:SqrtSteps];
  logic [QuotW-1:0] sval_r  [1:SqrtSteps];
  logic             shit_r  [1:SqrtSteps];
  logic             sv_cur    [SqrtSteps];
  logic [SremW-1:0] srem_cur  [SqrtSteps];
  logic [DistW-1:0] sroot_cur [SqrtSteps];
  logic [QuotW-1:0] sval_cur  [SqrtSteps];
  logic             shit_cur  [SqrtSteps];
  logic [SremW-1:0] srem_nxt  [SqrtSteps];
  logic [DistW-1:0] sroot_nxt [SqrtSteps];
  logic [SremW+1:0] s4r       [SqrtSteps];
  logic [SremW+1:0] strial    [SqrtSteps];

  assign busy = ~rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RadiusRst;
      r2_r     <= Radius2Rst;
    end else begin
      if (cfg_we) begin
        radius_r <= cfg_wdata;
      end
      r2_r <= R2W'(radius_r) * R2W'(radius_r);
    end
  end

  always_comb begin
    dx1_nxt = DiffW'(in0_r.end_x)   - DiffW'(in0_r.start_x);
    dy1_nxt = DiffW'(in0_r.end_y)   - DiffW'(in0_r.start_y);
    wx1_nxt = DiffW'(in0_r.point_x) - DiffW'(in0_r.start_x);
    wy1_nxt = DiffW'(in0_r.point_y) - DiffW'(in0_r.start_y);
    ux1_nxt = DiffW'(in0_r.point_x) - DiffW'(in0_r.end_x);
    uy1_nxt = DiffW'(in0_r.point_y) - DiffW'(in0_r.end_y);
  end

  always_comb begin
    t_pos     = !t3_r[DotW-1] && (t3_r != '0);
    perp4_nxt = (dd3_r != '0) && t_pos && (t3_r[ProdW-1:0] < dd3_r);
    c4_nxt    = cr3_r[DotW-1] ? ProdW'(-cr3_r) : ProdW'(cr3_r);
    den4_nxt  = perp4_nxt ? dd3_r : ProdW'(1);
    sq4_nxt   = ((dd3_r == '0) || !t_pos) ? sqa3_r : sqb3_r;
  end

  always_comb begin
    c2_6     = (SqW'(hh5_r) << (2 * HalfW)) + (SqW'(hl5_r) << (HalfW + 1)) + SqW'(ll5_r);
    num6_nxt = perp5_r ? c2_6 : SqW'(sq5_r);
  end

  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      dtry[k] = {drem_r[k], dnb_r[k][QuotW-1]};
      if (dtry[k] >= {1'b0, dden_r[k]}) begin
        drem_nxt[k] = ProdW'(dtry[k] - {1'b0, dden_r[k]});
        dq_nxt[k]   = {dq_r[k][QuotW-2:0], 1'b1};
      end else begin
        drem_nxt[k] = dtry[k][ProdW-1:0];
        dq_nxt[k]   = {dq_r[k][QuotW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    sv_cur[0]    = dv_r[DivSteps];
    srem_cur[0]  = '0;
    sroot_cur[0] = '0;
    sval_cur[0]  = dq_r[DivSteps];
    shit_cur[0]  = dhit_r[DivSteps];
    for (int k = 1; k < SqrtSteps; k++) begin
      sv_cur[k]    = sv_r[k];
      srem_cur[k]  = srem_r[k];
      sroot_cur[k] = sroot_r[k];
      sval_cur[k]  = sval_r[k];
      shit_cur[k]  = shit_r[k];
    end
  end

  always_comb begin
    for (int k = 0; k < SqrtSteps; k++) begin
      s4r[k]    = {srem_cur[k], sval_cur[k][QuotW-1:QuotW-2]};
      strial[k] = (SremW+2)'({sroot_cur[k], 2'b01});
      if (s4r[k] >= strial[k]) begin
        srem_nxt[k]  = SremW'(s4r[k] - strial[k]);
        sroot_nxt[k] = {sroot_cur[k][DistW-2:0], 1'b1};
      end else begin
        srem_nxt[k]  = s4r[k][SremW-1:0];
        sroot_nxt[k] = {sroot_cur[k][DistW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      for (int k = 0; k <= DivSteps; k++) begin
        dv_r[k] <= 1'b0;
      end
      for (int k = 1; k <= SqrtSteps; k++) begin
        sv_r[k] <= 1'b0;
      end
    end else begin
      v0_r    <= start && !busy;
      v1_r    <= v0_r;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      v6_r    <= v5_r;
      dv_r[0] <= v6_r;
      for (int k = 0; k < DivSteps; k++) begin
        dv_r[k+1] <= dv_r[k];
      end
      for (int k = 0; k < SqrtSteps; k++) begin
        sv_r[k+1] <= sv_cur[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    in0_r <= in_data;

    dx1_r <= dx1_nxt;
    dy1_r <= dy1_nxt;
    wx1_r <= wx1_nxt;
    wy1_r <= wy1_nxt;
    ux1_r <= ux1_nxt;
    uy1_r <= uy1_nxt;

    pdx2_r <= ProdW'(dx1_r) * ProdW'(dx1_r);
    pdy2_r <= ProdW'(dy1_r) * ProdW'(dy1_r);
    ptx2_r <= ProdW'(wx1_r) * ProdW'(dx1_r);
    pty2_r <= ProdW'(wy1_r) * ProdW'(dy1_r);
    pca2_r <= ProdW'(wx1_r) * ProdW'(dy1_r);
    pcb2_r <= ProdW'(wy1_r) * ProdW'(dx1_r);
    pax2_r <= ProdW'(wx1_r) * ProdW'(wx1_r);
    pay2_r <= ProdW'(wy1_r) * ProdW'(wy1_r);
    pbx2_r <= ProdW'(ux1_r) * ProdW'(ux1_r);
    pby2_r <= ProdW'(uy1_r) * ProdW'(uy1_r);

    dd3_r  <= $unsigned(pdx2_r) + $unsigned(pdy2_r);
    sqa3_r <= $unsigned(pax2_r) + $unsigned(pay2_r);
    sqb3_r <= $unsigned(pbx2_r) + $unsigned(pby2_r);
    t3_r   <= DotW'(ptx2_r) + DotW'(pty2_r);
    cr3_r  <= DotW'(pca2_r) - DotW'(pcb2_r);

    perp4_r <= perp4_nxt;
    c4_r    <= c4_nxt;
    den4_r  <= den4_nxt;
    sq4_r   <= sq4_nxt;

    perp5_r <= perp4_r;
    sq5_r   <= sq4_r;
    den5_r  <= den4_r;
    hh5_r   <= ProdW'(c4_r[ProdW-1:HalfW]) * ProdW'(c4_r[ProdW-1:HalfW]);
    hl5_r   <= ProdW'(c4_r[ProdW-1:HalfW]) * ProdW'(c4_r[HalfW-1:0]);
    ll5_r   <= ProdW'(c4_r[HalfW-1:0]) * ProdW'(c4_r[HalfW-1:0]);
    rh5_r   <= (R2W+HalfW)'(r2_r) * (R2W+HalfW)'(den4_r[ProdW-1:HalfW]);
    rl5_r   <= (R2W+HalfW)'(r2_r) * (R2W+HalfW)'(den4_r[HalfW-1:0]);

    num6_r <= num6_nxt;
    rd6_r  <= (RdW'(rh5_r) << HalfW) + RdW'(rl5_r);
    den6_r <= den5_r;

    // numerator is num * 2^8; quotient fits 42 bits so the top bits start as remainder
    drem_r[0] <= num6_r[SqW-1:SqW-ProdW];
    dnb_r[0]  <= {num6_r[SqW-ProdW-1:0], 8'b0};
    dq_r[0]   <= '0;
    dden_r[0] <= den6_r;
    dhit_r[0] <= num6_r < SqW'(rd6_r);
    for (int k = 0; k < DivSteps; k++) begin
      drem_r[k+1] <= drem_nxt[k];
      dnb_r[k+1]  <= {dnb_r[k][QuotW-2:0], 1'b0};
      dq_r[k+1]   <= dq_nxt[k];
      dden_r[k+1] <= dden_r[k];
      dhit_r[k+1] <= dhit_r[k];
    end

    for (int k = 0; k < SqrtSteps; k++) begin
      srem_r[k+1]  <= srem_nxt[k];
      sroot_r[k+1] <= sroot_nxt[k];
      sval_r[k+1]  <= {sval_cur[k][QuotW-3:0], 2'b00};
      shit_r[k+1]  <= shit_cur[k];
    end
  end

  assign out_strobe            = sv_r[SqrtSteps];
  assign out_data.seg_distance = sroot_r[SqrtSteps];
  assign out_data.hit          = shit_r[SqrtSteps];

  a_hit_below_radius: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.hit |->
      out_data.seg_distance < {radius_r, {FracBits{1'b0}}})
    else $error("hit with distance not below radius");

  a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (radius_r == '0) |-> !out_data.hit)
    else $error("hit with zero radius");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[DivSteps] |-> drem_r[DivSteps] < dden_r[DivSteps])
    else $error("divider remainder not below divisor");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> srem_r[SqrtSteps] <= SremW'({sroot_r[SqrtSteps], 1'b0}))
    else $error("root remainder out of range");

endmodule

// ===== tb/point_segment_distance_hit_test_checker.sv =====
module point_segment_distance_hit_test_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  psdht_pkg::in_t               in_data,
  input  logic                         out_strobe,
  input  psdht_pkg::out_t              out_data,
  input  logic                         cfg_we,
  input  logic [psdht_pkg::CoordW-1:0] cfg_wdata,
  output int                           fails,
  output int                           pending
);
  import psdht_pkg::*;

  logic [CoordW-1:0] radius;
  out_t              dist_q[$];

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic out_t seg_distance_of(in_t p, logic [CoordW-1:0] rad);
    longint px, py, ax, ay, bx, by, dx, dy, wx, wy, t, dd, ex, ey, c;
    logic [127:0] c2, dd_w, r2;
    logic [63:0]  sq, q;
    out_t r;
    px = p.point_x; py = p.point_y;
    ax = p.start_x; ay = p.start_y;
    bx = p.end_x;   by = p.end_y;
    dx = bx - ax; dy = by - ay;
    wx = px - ax; wy = py - ay;
    dd = dx * dx + dy * dy;
    t = wx * dx + wy * dy;
    r2 = 128'(rad) * 128'(rad);
    if (dd == 0 || t <= 0 || t >= dd) begin
      if (dd == 0 || t <= 0) begin
        ex = wx; ey = wy;
      end else begin
        ex = px - bx; ey = py - by;
      end
      sq = ex * ex + ey * ey;
      r.seg_distance = DistW'(int_sqrt(sq << 8));
      r.hit = 128'(sq) < r2;
    end else begin
      c = wx * dy - wy * dx;
      if (c < 0) c = -c;
      c2 = 128'(c) * 128'(c);
      dd_w = 128'(dd);
      q = 64'((c2 << 8) / dd_w);
      r.seg_distance = DistW'(int_sqrt(q));
      r.hit = c2 < r2 * dd_w;
    end
    return r;
  endfunction

  task automatic report(string what, out_t got, out_t want);
    $display("distance check error (%s): got dist=%0d hit=%0d, want dist=%0d hit=%0d",
             what, got.seg_distance, got.hit, want.seg_distance, want.hit);
    fails = fails + 1;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      radius = RadiusRst;
      dist_q.delete();
      fails = 0;
    end else begin
      if (cfg_we) radius = cfg_wdata;
      if (start && !busy) dist_q = {dist_q, seg_distance_of(in_data, radius)};
      if (out_strobe) begin
        if (dist_q.size() == 0) begin
          report("unexpected transfer", out_data, out_data);
        end else begin
          want = dist_q.pop_front();
          if (out_data.seg_distance !== want.seg_distance) report("seg_distance", out_data, want);
          if (out_data.hit !== want.hit) report("hit", out_data, want);
        end
      end
    end
    pending <= dist_q.size();
  end

endmodule

// ===== tb/point_segment_distance_hit_test_test.sv =====
module point_segment_distance_hit_test_test;
  import psdht_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_t               in_data = '0;
  logic              out_strobe;
  out_t              out_data;
  logic              cfg_we = 1'b0;
  logic [CoordW-1:0] cfg_wdata = '0;
  int                fails;
  int                pending;
  int                idle_left;
  bit                quiet;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_segment_distance_hit_test dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  point_segment_distance_hit_test_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending)
  );

  function automatic in_t seg(int px, int py, int ax, int ay, int bx, int by);
    in_t s;
    s.point_x = CoordW'(px); s.point_y = CoordW'(py);
    s.start_x = CoordW'(ax); s.start_y = CoordW'(ay);
    s.end_x = CoordW'(bx);   s.end_y = CoordW'(by);
    return s;
  endfunction

  function automatic logic [15:0] extreme();
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  function automatic in_t random_seg();
    in_t s;
    int  bx, by, span;
    s = in_t'({$urandom, $urandom, $urandom});
    bx = int'($signed(16'($urandom)));
    by = int'($signed(16'($urandom)));
    span = 1 << $urandom_range(1, 8);
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3, 4, 5: s = seg(bx + $urandom_range(0, 2 * span) - span, by + $urandom_range(0, 2 * span) - span,
                       bx + $urandom_range(0, 2 * span) - span, by + $urandom_range(0, 2 * span) - span,
                       bx + $urandom_range(0, 2 * span) - span, by + $urandom_range(0, 2 * span) - span);
      6: begin
        if ($urandom_range(0, 1)) s.end_y = s.start_y;
        else s.end_x = s.start_x;
      end
      7: begin
        s.end_x = s.start_x;
        s.end_y = s.start_y;
      end
      8: begin
        s.point_x = $urandom_range(0, 1) ? s.start_x : s.end_x;
        s.point_y = $urandom_range(0, 1) ? s.start_y : s.end_y;
      end
      default: s = seg(int'($signed(extreme())), int'($signed(extreme())),
                       int'($signed(extreme())), int'($signed(extreme())),
                       int'($signed(extreme())), int'($signed(extreme())));
    endcase
    return s;
  endfunction

  task automatic send(in_t s);
    if (!quiet && idle_left == 0 && $urandom_range(0, 7) == 0) idle_left = $urandom_range(1, 16);
    if (idle_left > 0) begin
      start <= 1'b0;
      repeat (idle_left) @(posedge clk);
      idle_left = 0;
    end
    start <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_radius(logic [CoordW-1:0] r);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    in_t dir_q[$];
    logic [CoordW-1:0] radii[6];
    idle_left = 0;
    quiet = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_q = '{
      seg(0, 0, 0, 0, 0, 0),
      seg(5, 0, 0, 0, 0, 0),
      seg(3, 4, 10, -7, 10, -7),
      seg(5, 9, 0, 0, 10, 0),
      seg(5, 10, 0, 0, 10, 0),
      seg(5, -3, 0, 0, 0, 10),
      seg(-4, 3, 0, 0, 10, 0),
      seg(14, 3, 0, 0, 10, 0),
      seg(0, 0, 0, 0, 10, 0),
      seg(10, 0, 0, 0, 10, 0),
      seg(4, 4, 0, 0, 9, 9),
      seg(1, 8, 0, 0, 7, 3),
      seg(-32768, -32768, 32767, 32767, 32767, -32768),
      seg(32767, 32767, -32768, -32768, -32768, 32767),
      seg(-32768, 32767, -32768, -32768, 32767, 32767),
      seg(32767, -32768, -32768, 32767, 32767, -32768),
      seg(-32768, -32768, 32767, 32767, 32767, 32767),
      seg(0, 0, -32768, 32767, 32767, -32768),
      seg(-1, -1, -1, -1, -1, -1),
      seg(100, 7, -32768, 0, 32767, 0),
      seg(7, 100, 0, -32768, 0, 32767)
    };
    foreach (dir_q[i]) send(dir_q[i]);

    radii = '{16'd0, 16'd65535, 16'd1, 16'd10, 16'd300, 16'($urandom)};
    foreach (dir_q[i]) send(dir_q[i]);
    for (int ph = 0; ph < 6; ph++) begin
      set_radius(radii[ph]);
      if (ph == 1) foreach (dir_q[i]) send(dir_q[i]);
      if (ph == 5) quiet = 1;
      for (int n = 0; n < 120; n++) send(random_seg());
    end

    drain();
    repeat (80) @(posedge clk);
    if (fails == 0) begin
      $display("point_segment_distance_hit_test: match");
    end else begin
      $display("point_segment_distance_hit_test: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("point_segment_distance_hit_test: mismatch");
    $finish;
  end
endmodule

// ===== point_segment_distance_hit_test.f =====
rtl/psdht_pkg.sv
rtl/point_segment_distance_hit_test.sv
tb/point_segment_distance_hit_test_checker.sv
tb/point_segment_distance_hit_test_test.sv
